@@ sv/assert_macros.svh @@
// assertion macros used by the checker file
// needs clk and arst_n in the scope of each use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain property, sampled on clk, off during reset
`define CLCD_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// same-cycle implication
`define CLCD_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define CLCD_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ sv/clcd_pkg.sv @@
// types, codes and defaults of the character lcd refresh controller
// no dependencies; used by the top level and its checker
package clcd_pkg;

	localparam int DISPLAY_ROWS_DEF = 4;
	localparam int DISPLAY_COLS_DEF = 20;

	// item function codes
	localparam logic [1:0] FUNC_TICK  = 2'd0;
	localparam logic [1:0] FUNC_WRITE = 2'd1;
	localparam logic [1:0] FUNC_CLEAR = 2'd2;

	// bus action codes
	localparam logic [1:0] ACT_NONE = 2'd0;
	localparam logic [1:0] ACT_DATA = 2'd1;
	localparam logic [1:0] ACT_CMD  = 2'd2;
	localparam logic [1:0] ACT_BUSY = 2'd3;

	localparam logic [7:0] HOME_CMD   = 8'h02;
	localparam logic [7:0] SPACE_CHAR = 8'h20;

	// pending pass counts set by a write or clear
	localparam logic [1:0] PEND_FROM_IDLE = 2'd1;
	localparam logic [1:0] PEND_BUSY      = 2'd2;

	typedef enum logic [2:0] {
		PH_IDLE     = 3'd0,
		PH_PUTCHAR  = 3'd1,
		PH_RETURN   = 3'd2,
		PH_NEXTLINE = 3'd3,
		PH_WAIT     = 3'd4
	} phase_t;

	typedef struct packed {
		logic [1:0] func;
		logic [2:0] row;
		logic [6:0] column;
		logic [7:0] char_code;
		logic       busy_flag;
	} item_t;

	typedef struct packed {
		logic [1:0] bus_action;
		logic [7:0] bus_data;
		logic [2:0] out_state;
		logic [1:0] out_row;
		logic [4:0] out_col;
		logic [1:0] out_pending;
	} result_t;

endpackage

@@ sv/char_lcd_refresh_controller_top.sv @@
// character lcd refresh controller: frame store memory, phase machine, result register
// depends on clcd_pkg
//
// channel  direction  handshake                  payload
// item     in         item_valid / item_ready    item   (clcd_pkg::item_t)
// result   out        result_valid / result_ready result (clcd_pkg::result_t)
//
// every item takes one transfer in and gives exactly one result transfer out
// a result passes from its item transfer through the frame store read port
// of the read stage and then through the result register
// items are taken every cycle while the result side keeps up; the single
// memory access per item (read on a putchar tick, write on a character write)
// sets that figure
// reset leaves the store as all spaces at once through per-entry valid bits,
// so there is no clearing pass; a clear item drops all valid bits at once
// a stalled result holds the result register and then the read stage, and
// item_ready falls once both are full
module char_lcd_refresh_controller_top #(
	parameter int DISPLAY_ROWS = clcd_pkg::DISPLAY_ROWS_DEF,
	parameter int DISPLAY_COLS = clcd_pkg::DISPLAY_COLS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_ready,
	input  clcd_pkg::item_t   item,
	output logic              result_valid,
	input  logic              result_ready,
	output clcd_pkg::result_t result
);

	localparam int STORE  = DISPLAY_ROWS * DISPLAY_COLS;
	localparam int ADDR_W = $clog2(STORE);
	localparam int ROW_W  = (DISPLAY_ROWS > 1) ? $clog2(DISPLAY_ROWS) : 1;
	localparam int COL_W  = $clog2(DISPLAY_COLS);
	// write index may run past the store before the range check
	localparam int WIDX_W = $clog2(STORE + 128);

	// frame store and its valid bits (invalid entry reads as space)
	logic [7:0]       mem [STORE];
	logic [STORE-1:0] vld_q;

	// phase machine and cursor
	clcd_pkg::phase_t cur_q, nxt_q, cur_d, nxt_d;
	logic [ROW_W-1:0] row_q, row_d;
	logic [COL_W-1:0] col_q, col_d;
	logic [1:0]       pend_q, pend_d;

	// read stage
	logic              s1_valid_q;
	clcd_pkg::result_t res_s1;
	logic              mem_sel_s1;
	logic              hit_s1;
	logic [7:0]        rd_s1;

	// result register
	logic              out_valid_q;
	clcd_pkg::result_t out_q;

	logic              take;
	logic              s1_adv;
	logic              wr_ok;
	logic              wr_en;
	logic              clr_en;
	logic              rd_en;
	logic [WIDX_W-1:0] widx;
	logic [ADDR_W-1:0] waddr;
	logic [ADDR_W-1:0] raddr;
	logic [1:0]        act_d;
	logic [7:0]        data_d;
	logic [1:0]        pend_mark;
	clcd_pkg::result_t res_d;
	clcd_pkg::result_t res_fill;

	// handshake: the read stage empties into the result register when it is free
	assign s1_adv       = s1_valid_q && (!out_valid_q || result_ready);
	assign item_ready   = !s1_valid_q || s1_adv;
	assign take         = item_valid && item_ready;
	assign result_valid = out_valid_q;
	assign result       = out_q;

	// write address check: row first, then flat index against the store size
	assign widx  = WIDX_W'(WIDX_W'(item.row) * WIDX_W'(DISPLAY_COLS)) + WIDX_W'(item.column);
	assign wr_ok = (item.row < 3'(DISPLAY_ROWS)) && (widx < WIDX_W'(STORE));
	assign waddr = widx[ADDR_W-1:0];

	// cursor address for putchar
	assign raddr = ADDR_W'(ADDR_W'(row_q) * ADDR_W'(DISPLAY_COLS)) + ADDR_W'(col_q);

	// a write or clear owes one pass from idle, two if a pass is running
	assign pend_mark = (cur_q == clcd_pkg::PH_IDLE) ? clcd_pkg::PEND_FROM_IDLE
		: clcd_pkg::PEND_BUSY;

	// next state: a tick first adopts the phase chosen on the tick before
	always_comb begin
		cur_d  = cur_q;
		nxt_d  = nxt_q;
		row_d  = row_q;
		col_d  = col_q;
		pend_d = pend_q;
		wr_en  = 1'b0;
		clr_en = 1'b0;
		case (item.func)
			clcd_pkg::FUNC_TICK: begin
				cur_d = nxt_q;
				case (nxt_q)
					clcd_pkg::PH_IDLE: begin
						nxt_d = (pend_q == 2'd0) ? clcd_pkg::PH_IDLE : clcd_pkg::PH_PUTCHAR;
					end
					clcd_pkg::PH_PUTCHAR: begin
						if (col_q == COL_W'(DISPLAY_COLS - 1)) begin
							col_d = '0;
							nxt_d = clcd_pkg::PH_NEXTLINE;
						end else begin
							col_d = col_q + 1'b1;
							nxt_d = clcd_pkg::PH_WAIT;
						end
					end
					clcd_pkg::PH_RETURN: begin
						nxt_d = clcd_pkg::PH_WAIT;
						if (pend_q != 2'd0) begin
							pend_d = pend_q - 2'd1;
						end
					end
					clcd_pkg::PH_NEXTLINE: begin
						if (row_q == ROW_W'(DISPLAY_ROWS - 1)) begin
							row_d = '0;
							nxt_d = clcd_pkg::PH_RETURN;
						end else begin
							row_d = row_q + 1'b1;
							nxt_d = clcd_pkg::PH_WAIT;
						end
					end
					clcd_pkg::PH_WAIT: begin
						if (item.busy_flag) begin
							nxt_d = clcd_pkg::PH_WAIT;
						end else begin
							nxt_d = (pend_q == 2'd0) ? clcd_pkg::PH_IDLE
								: clcd_pkg::PH_PUTCHAR;
						end
					end
					default: begin
						cur_d = clcd_pkg::PH_IDLE;
						nxt_d = clcd_pkg::PH_IDLE;
					end
				endcase
			end
			clcd_pkg::FUNC_WRITE: begin
				if (wr_ok) begin
					wr_en  = 1'b1;
					pend_d = pend_mark;
				end
			end
			clcd_pkg::FUNC_CLEAR: begin
				clr_en = 1'b1;
				pend_d = pend_mark;
			end
			default: begin
				// unused code leaves everything as is
			end
		endcase
	end

	// outputs: bus action of the executed phase, and whether the byte comes from the store
	always_comb begin
		act_d  = clcd_pkg::ACT_NONE;
		data_d = 8'h00;
		rd_en  = 1'b0;
		if (take && (item.func == clcd_pkg::FUNC_TICK)) begin
			case (nxt_q)
				clcd_pkg::PH_PUTCHAR: begin
					act_d = clcd_pkg::ACT_DATA;
					rd_en = 1'b1;
				end
				clcd_pkg::PH_RETURN: begin
					act_d  = clcd_pkg::ACT_CMD;
					data_d = clcd_pkg::HOME_CMD;
				end
				clcd_pkg::PH_WAIT: begin
					act_d = clcd_pkg::ACT_BUSY;
				end
				default: begin
					act_d = clcd_pkg::ACT_NONE;
				end
			endcase
		end
		res_d.bus_action  = act_d;
		res_d.bus_data    = data_d;
		res_d.out_state   = cur_d;
		res_d.out_row     = 2'(row_d);
		res_d.out_col     = 5'(col_d);
		res_d.out_pending = pend_d;
	end

	// putchar byte arrives registered from the read port, in the cycle after the transfer
	always_comb begin
		res_fill = res_s1;
		if (mem_sel_s1) begin
			res_fill.bus_data = hit_s1 ? rd_s1 : clcd_pkg::SPACE_CHAR;
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q       <= clcd_pkg::PH_IDLE;
			nxt_q       <= clcd_pkg::PH_IDLE;
			row_q       <= '0;
			col_q       <= '0;
			pend_q      <= 2'd0;
			vld_q       <= '0;
			s1_valid_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (take) begin
				cur_q  <= cur_d;
				nxt_q  <= nxt_d;
				row_q  <= row_d;
				col_q  <= col_d;
				pend_q <= pend_d;
				if (clr_en) begin
					vld_q <= '0;
				end else if (wr_en) begin
					vld_q[waddr] <= 1'b1;
				end
			end
			if (take) begin
				s1_valid_q <= 1'b1;
			end else if (s1_adv) begin
				s1_valid_q <= 1'b0;
			end
			if (s1_adv) begin
				out_valid_q <= 1'b1;
			end else if (result_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// frame store: one access per item, the read data and valid bit are
	// captured at the tick's transfer, so a later write cannot disturb them
	always_ff @(posedge clk) begin
		if (take && wr_en) begin
			mem[waddr] <= item.char_code;
		end
		if (rd_en) begin
			rd_s1  <= mem[raddr];
			hit_s1 <= vld_q[raddr];
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (take) begin
			res_s1     <= res_d;
			mem_sel_s1 <= rd_en;
		end
		if (s1_adv) begin
			out_q <= res_fill;
		end
	end

endmodule

@@ sv/clcd_checker.sv @@
// port-level checks of the character lcd refresh controller, bound to its top level
// depends on clcd_pkg and assert_macros.svh
`include "assert_macros.svh"

module clcd_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              result_valid,
	input logic              result_ready,
	input clcd_pkg::result_t result
);

	// a stalled result transfer holds its payload
	`CLCD_ASSERT_NEXT(a_res_hold, result_valid && !result_ready, result_valid && $stable(result), "stalled result changed")

	// no byte on the bus unless something is written
	`CLCD_ASSERT_IMPL(a_idle_bus, result_valid && (result.bus_action == clcd_pkg::ACT_NONE || result.bus_action == clcd_pkg::ACT_BUSY), result.bus_data == 8'h00, "bus data without a write")

	// a command write is always the home command from the return phase
	`CLCD_ASSERT_IMPL(a_cmd_home, result_valid && result.bus_action == clcd_pkg::ACT_CMD, result.bus_data == clcd_pkg::HOME_CMD && result.out_state == clcd_pkg::PH_RETURN, "bad command write")

	// data writes come only from putchar; this check does not cover busy reads from wait
	`CLCD_ASSERT_IMPL(a_act_phase, result_valid && result.bus_action == clcd_pkg::ACT_DATA, result.out_state == clcd_pkg::PH_PUTCHAR, "data write outside putchar")

	// never more than two passes owed
	`CLCD_ASSERT(a_pend_max, !result_valid || result.out_pending != 2'd3, "pending count overflow")

endmodule

bind char_lcd_refresh_controller_top clcd_checker u_clcd_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.result_valid (result_valid),
	.result_ready (result_ready),
	.result       (result)
);
